@@ rtl/ipfr_pkg.sv @@
// Shared constants and slot helpers for the IPv4 fragment reassembly tracker.
`default_nettype none
package ipfr_pkg;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_FRAGS_DEF     = 16;

    localparam int SLOT_W = 42;
    localparam int KEY_W  = 80;

    localparam logic [2:0] ST_DELIVER  = 3'd0;
    localparam logic [2:0] ST_TBL_FULL = 3'd1;
    localparam logic [2:0] ST_TOO_MANY = 3'd2;
    localparam logic [2:0] ST_EXPIRED  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [15:0] TIMEOUT_RST = 16'd30;
    localparam logic [15:0] MAXLEN_RST  = 16'hFFFF;

    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_MAXLEN  = 3'd4;

    // slot: handle [9:0], frag word [25:10], length [41:26]
    function automatic logic [15:0] slot_off(input logic [SLOT_W-1:0] s);
        slot_off = {s[22:10], 3'b000};
    endfunction

    function automatic logic [15:0] slot_len(input logic [SLOT_W-1:0] s);
        slot_len = s[41:26];
    endfunction
endpackage
`default_nettype wire

@@ rtl/ipfr_key_ram.sv @@
// Entry key memory: source, destination and ident per table entry.
`default_nettype none
module ipfr_key_ram
    import ipfr_pkg::*;
#(
    parameter int DEPTH = TABLE_ENTRIES_DEF,
    parameter int AW    = 4
)(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [KEY_W-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [KEY_W-1:0]  rdata
);
    logic [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/ipfr_slot_ram.sv @@
// Fragment slot memory: per entry, fragments kept in offset order.
`default_nettype none
module ipfr_slot_ram
    import ipfr_pkg::*;
#(
    parameter int DEPTH = TABLE_ENTRIES_DEF * MAX_FRAGS_DEF,
    parameter int AW    = 8
)(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [SLOT_W-1:0]  wdata,
    input  wire logic               re,
    input  wire logic [AW-1:0]      raddr,
    output logic      [SLOT_W-1:0]  rdata
);
    logic [SLOT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/ipv4_fragment_reassembly_tracker_unit.sv @@
// Top level of the IPv4 fragment reassembly tracker.
// Handles one word at a time. A fragment scans the key memory entry by entry
// (a read state and a compare state per entry), then does a sorted insert over
// the entry's slot memory, reading and writing each held fragment and placing the
// new one, then on completion emits one result per fragment (held while m_tready
// stalls). A tick decrements every countdown, scans for an expired entry and, on
// expiry, runs a sum pass and an emit pass over that entry's fragments. Each pass
// goes one slot at a time through the single read port of each memory.
`default_nettype none
module ipv4_fragment_reassembly_tracker_unit
    import ipfr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_FRAGS     = MAX_FRAGS_DEF
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // src_ip, dst_ip, ident, frag_word, payload_len, buf_handle, zero pad
    input  wire logic [127:0] s_tdata,
    // cmd
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_handle, frag_offset, frag_len, total_len, zero pad
    output logic      [63:0]  m_tdata,
    // status
    output logic      [2:0]   m_tuser,
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_FRAGS + 1);
    localparam int SAW = $clog2(TABLE_ENTRIES * MAX_FRAGS);
    localparam int TW  = 16 + CW;
    localparam logic [EW-1:0]  LAST_E = EW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0]  MF_C   = CW'(MAX_FRAGS);
    localparam logic [SAW-1:0] MF_A   = SAW'(MAX_FRAGS);

    typedef enum logic [3:0] {
        S_IDLE, S_TDEC, S_TSCAN, S_KRD, S_KCMP, S_NEW, S_DROP, S_IRD, S_IWR,
        S_CHK, S_SRD, S_SACC, S_ERD, S_ELD, S_REL
    } state_t;

    state_t state_reg;

    logic [15:0] timeout_reg, maxlen_reg;
    logic [63:0] key_reg;
    logic [15:0] ident_reg, word_reg, len_reg;
    logic [9:0]  handle_reg;
    logic [EW-1:0] idx_reg, e_reg, free_reg;
    logic        free_found_reg;
    logic [CW-1:0] i_reg, n_reg;
    logic        placed_reg, ok_reg;
    logic [SLOT_W-1:0] hold_reg;
    logic [TW-1:0] run_reg;
    logic [2:0]  status_reg;

    logic          valid_arr [TABLE_ENTRIES];
    logic [CW-1:0] cnt_arr   [TABLE_ENTRIES];
    logic          ls_arr    [TABLE_ENTRIES];
    logic [15:0]   cd_arr    [TABLE_ENTRIES];

    logic        m_tvalid_reg, m_tlast_reg;
    logic [2:0]  m_status_reg;
    logic [9:0]  m_handle_reg;
    logic [15:0] m_off_reg, m_len_reg, m_total_reg;

    logic [EW-1:0] sel_e;
    logic          sel_valid, sel_ls;
    logic [CW-1:0] sel_cnt;
    logic [15:0]   sel_cd;

    logic              key_re, key_we, slot_re, slot_we;
    logic [KEY_W-1:0]  key_rdata;
    logic [SLOT_W-1:0] slot_rdata, slot_wdata, new_slot, fin_slot;
    logic [SAW-1:0]    slot_raddr, slot_waddr, base_a;
    logic [15:0]       new_off;
    logic              at_end, put_new, out_free, key_hit;
    logic [TW-1:0]     run_add;
    logic [15:0]       sum_sat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, maxlen_reg} : {16'd0, timeout_reg};

    assign sel_e     = (state_reg == S_KCMP || state_reg == S_TSCAN) ? idx_reg : e_reg;
    assign sel_valid = valid_arr[sel_e];
    assign sel_cnt   = cnt_arr[sel_e];
    assign sel_ls    = ls_arr[sel_e];
    assign sel_cd    = cd_arr[sel_e];

    assign new_off  = {word_reg[12:0], 3'b000};
    assign new_slot = {len_reg, word_reg, handle_reg};
    assign base_a   = SAW'(e_reg) * MF_A;
    assign at_end   = (i_reg == n_reg);
    assign put_new  = !placed_reg && (at_end || slot_off(slot_rdata) >= new_off);
    assign fin_slot = placed_reg ? hold_reg : (put_new ? new_slot : slot_rdata);
    assign run_add  = run_reg + TW'(slot_len(fin_slot));
    assign sum_sat  = (run_reg > TW'(16'hFFFF)) ? 16'hFFFF : run_reg[15:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign key_hit  = sel_valid && key_rdata == {key_reg, ident_reg};

    assign key_re     = (state_reg == S_KRD);
    assign key_we     = (state_reg == S_NEW);
    assign slot_re    = (state_reg == S_IRD || state_reg == S_SRD || state_reg == S_ERD);
    assign slot_raddr = base_a + SAW'(i_reg);
    assign slot_we    = (state_reg == S_NEW) || (state_reg == S_IWR && (placed_reg || put_new));
    assign slot_waddr = (state_reg == S_NEW) ? base_a : base_a + SAW'(i_reg);
    assign slot_wdata = (state_reg == S_NEW) ? new_slot : fin_slot;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {6'd0, m_total_reg, m_len_reg, m_off_reg, m_handle_reg};

    ipfr_key_ram #(.DEPTH(TABLE_ENTRIES), .AW(EW)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (e_reg),
        .wdata ({key_reg, ident_reg}),
        .re    (key_re),
        .raddr (idx_reg),
        .rdata (key_rdata)
    );

    ipfr_slot_ram #(.DEPTH(TABLE_ENTRIES * MAX_FRAGS), .AW(SAW)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            timeout_reg  <= TIMEOUT_RST;
            maxlen_reg   <= MAXLEN_RST;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                valid_arr[k] <= 1'b0;
                cnt_arr[k]   <= '0;
                ls_arr[k]    <= 1'b0;
                cd_arr[k]    <= '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2])
                begin
                    maxlen_reg <= pwdata[15:0];
                end
                else
                begin
                    timeout_reg <= pwdata[15:0];
                end
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        key_reg        <= {s_tdata[31:0], s_tdata[63:32]};
                        ident_reg      <= s_tdata[79:64];
                        word_reg       <= s_tdata[95:80];
                        len_reg        <= s_tdata[111:96];
                        handle_reg     <= s_tdata[121:112];
                        idx_reg        <= '0;
                        free_found_reg <= 1'b0;
                        state_reg      <= s_tuser ? S_TDEC : S_KRD;
                    end
                end
                S_TDEC:
                begin
                    for (int k = 0; k < TABLE_ENTRIES; k++)
                    begin
                        if (valid_arr[k] && cd_arr[k] != 16'd0)
                        begin
                            cd_arr[k] <= cd_arr[k] - 16'd1;
                        end
                    end
                    state_reg <= S_TSCAN;
                end
                S_TSCAN:
                begin
                    if (sel_valid && sel_cd == 16'd0)
                    begin
                        e_reg     <= idx_reg;
                        n_reg     <= sel_cnt;
                        i_reg     <= '0;
                        run_reg   <= '0;
                        state_reg <= S_SRD;
                    end
                    else if (idx_reg == LAST_E)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_KRD:
                begin
                    state_reg <= S_KCMP;
                end
                S_KCMP:
                begin
                    if (key_hit)
                    begin
                        e_reg <= idx_reg;
                        n_reg <= sel_cnt;
                        if (sel_cnt >= MF_C)
                        begin
                            status_reg <= ST_TOO_MANY;
                            state_reg  <= S_DROP;
                        end
                        else
                        begin
                            i_reg      <= '0;
                            placed_reg <= 1'b0;
                            run_reg    <= '0;
                            ok_reg     <= 1'b1;
                            state_reg  <= S_IRD;
                        end
                    end
                    else
                    begin
                        if (!sel_valid && !free_found_reg)
                        begin
                            free_reg       <= idx_reg;
                            free_found_reg <= 1'b1;
                        end
                        if (idx_reg == LAST_E)
                        begin
                            if (free_found_reg)
                            begin
                                e_reg     <= free_reg;
                                state_reg <= S_NEW;
                            end
                            else if (!sel_valid)
                            begin
                                e_reg     <= idx_reg;
                                state_reg <= S_NEW;
                            end
                            else
                            begin
                                status_reg <= ST_TBL_FULL;
                                state_reg  <= S_DROP;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_KRD;
                        end
                    end
                end
                S_NEW:
                begin
                    valid_arr[e_reg] <= 1'b1;
                    cnt_arr[e_reg]   <= CW'(1);
                    ls_arr[e_reg]    <= ~word_reg[13];
                    cd_arr[e_reg]    <= timeout_reg;
                    state_reg        <= S_IDLE;
                end
                S_DROP:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= status_reg;
                        m_handle_reg <= handle_reg;
                        m_off_reg    <= new_off;
                        m_len_reg    <= len_reg;
                        m_total_reg  <= 16'd0;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_IRD:
                begin
                    state_reg <= S_IWR;
                end
                S_IWR:
                begin
                    if (put_new || placed_reg)
                    begin
                        placed_reg <= 1'b1;
                        hold_reg   <= slot_rdata;
                    end
                    if (TW'(slot_off(fin_slot)) != run_reg)
                    begin
                        ok_reg <= 1'b0;
                    end
                    run_reg <= run_add;
                    if (at_end)
                    begin
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_IRD;
                    end
                end
                S_CHK:
                begin
                    cnt_arr[e_reg] <= n_reg + 1'b1;
                    ls_arr[e_reg]  <= sel_ls | ~word_reg[13];
                    cd_arr[e_reg]  <= timeout_reg;
                    n_reg          <= n_reg + 1'b1;
                    i_reg          <= '0;
                    status_reg     <= (run_reg > TW'(maxlen_reg)) ? ST_OVERFLOW : ST_DELIVER;
                    if ((sel_ls || !word_reg[13]) && n_reg != '0 && ok_reg)
                    begin
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SACC;
                end
                S_SACC:
                begin
                    run_reg <= run_reg + TW'(slot_len(slot_rdata));
                    if (i_reg == n_reg - 1'b1)
                    begin
                        i_reg      <= '0;
                        status_reg <= ST_EXPIRED;
                        state_reg  <= S_ERD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_ELD;
                end
                S_ELD:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= status_reg;
                        m_handle_reg <= slot_rdata[9:0];
                        m_off_reg    <= slot_off(slot_rdata);
                        m_len_reg    <= slot_len(slot_rdata);
                        m_total_reg  <= sum_sat;
                        m_tlast_reg  <= (i_reg == n_reg - 1'b1);
                        if (i_reg == n_reg - 1'b1)
                        begin
                            state_reg <= S_REL;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                S_REL:
                begin
                    valid_arr[e_reg] <= 1'b0;
                    cnt_arr[e_reg]   <= '0;
                    ls_arr[e_reg]    <= 1'b0;
                    cd_arr[e_reg]    <= '0;
                    state_reg        <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= ST_OVERFLOW))
        else $error("bad status code");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHK |-> n_reg < MF_C)
        else $error("insert into full fragment list");

    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == S_DROP) && m_tvalid && $rose(m_tvalid) |-> m_tlast)
        else $error("drop result without last");
endmodule
`default_nettype wire
